FILE: hdl/wmf_pkg.sv
// Shared types and constants for the windowed median / majority filter.
package wmf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TDATA_W  = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    S_FILL,
    S_EVAL,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam logic OP_MEDIAN = 1'b0;
  localparam logic OP_MODE   = 1'b1;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic step;
    logic first;
  } scan_ctrl_t;

endpackage

FILE: hdl/wmf_cell.sv
// One sorting cell: holds one window entry and trades it with its neighbors.
module wmf_cell (
  input  logic                clk,
  input  logic                rst,
  input  wmf_pkg::cell_ctrl_t ctrl,
  input  wmf_pkg::sample_t    sample,
  input  wmf_pkg::sample_t    prev_value,
  input  logic                prev_valid,
  input  logic                prev_gt,
  input  wmf_pkg::sample_t    next_value,
  output wmf_pkg::sample_t    value,
  output logic                valid,
  output logic                gt
);
  import wmf_pkg::*;

  assign gt = !valid || (value > sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert && gt) begin
      valid <= prev_gt ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      value <= prev_gt ? prev_value : sample;
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule

FILE: hdl/wmf_mode_scan.sv
// Run-length scanner that finds the most frequent value of a sorted stream.
module wmf_mode_scan #(
  parameter int WINDOW = 5
) (
  input  logic                clk,
  input  wmf_pkg::scan_ctrl_t ctrl,
  input  wmf_pkg::sample_t    value,
  output wmf_pkg::sample_t    best
);
  import wmf_pkg::*;

  localparam int CW = $clog2(WINDOW + 1);

  sample_t       prev;
  logic [CW-1:0] run;
  logic [CW-1:0] best_count;
  logic [CW-1:0] run_next;

  assign run_next = (value == prev) ? run + CW'(1) : CW'(1);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      prev <= value;
      if (ctrl.first) begin
        run        <= CW'(1);
        best_count <= CW'(1);
        best       <= value;
      end else begin
        run <= run_next;
        if (run_next > best_count) begin
          best_count <= run_next;
          best       <= value;
        end
      end
    end
  end

endmodule

FILE: hdl/window_median_or_mode_filter_core.sv
// Top level: window of sorting cells with median tap and majority scanner.
// A word that completes a window moves the core to S_EVAL, which registers the
// median; for the most frequent value S_SCAN shifts the cell row through the
// scanner and S_EMIT registers the result. Throughput: one word per cycle while
// a window fills; input stalls while a window is evaluated or scanned.
// Reset: rst (synchronous) empties the window and drops any pending result.
module window_median_or_mode_filter_core #(
  parameter int WINDOW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [wmf_pkg::TDATA_W-1:0]  s_axis_tdata,  // [11:0] sample
  input  logic                         s_axis_tuser,  // [0] op
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [wmf_pkg::TDATA_W-1:0]  m_axis_tdata   // [11:0] filtered_value
);
  import wmf_pkg::*;

  localparam int FW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID = WINDOW / 2;

  state_t        state, state_next;
  logic [FW-1:0] fill_count;
  logic [FW-1:0] scan_idx;
  logic          op_q;
  sample_t       result;
  sample_t       sample;
  cell_ctrl_t    cell_ctrl;
  scan_ctrl_t    scan_ctrl;
  sample_t       best;
  logic          accept;
  logic          complete;
  logic          out_free;
  logic          load_out;

  sample_t       cell_value [WINDOW];
  logic [WINDOW-1:0] cell_valid;
  logic [WINDOW-1:0] cell_gt;
  logic [WINDOW-1:0] ordered;

  assign sample   = s_axis_tdata[SAMPLE_W-1:0];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign complete = (fill_count == FW'(WINDOW - 1));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  genvar g;
  generate
    for (g = 0; g < WINDOW; g++) begin : g_cell
      sample_t pv;
      logic    pvl;
      logic    pgt;
      sample_t nv;
      if (g == 0) begin : g_head
        assign pv  = '0;
        assign pvl = 1'b0;
        assign pgt = 1'b0;
      end else begin : g_body
        assign pv  = cell_value[g-1];
        assign pvl = cell_valid[g-1];
        assign pgt = cell_gt[g-1];
      end
      if (g == WINDOW - 1) begin : g_tail
        assign nv = cell_value[g];
      end else begin : g_inner
        assign nv = cell_value[g+1];
      end
      wmf_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl),
        .sample     (sample),
        .prev_value (pv),
        .prev_valid (pvl),
        .prev_gt    (pgt),
        .next_value (nv),
        .value      (cell_value[g]),
        .valid      (cell_valid[g]),
        .gt         (cell_gt[g])
      );
      if (g == 0) begin : g_ord0
        assign ordered[g] = 1'b1;
      end else begin : g_ordn
        assign ordered[g] = (cell_value[g-1] <= cell_value[g]);
      end
    end
  endgenerate

  wmf_mode_scan #(
    .WINDOW (WINDOW)
  ) u_scan (
    .clk   (clk),
    .ctrl  (scan_ctrl),
    .value (cell_value[0]),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_axis_tready    = 1'b0;
    cell_ctrl        = '0;
    scan_ctrl        = '0;
    load_out         = 1'b0;
    result           = best;
    unique case (state)
      S_FILL: begin
        s_axis_tready    = 1'b1;
        cell_ctrl.insert = s_axis_tvalid;
        if (s_axis_tvalid && complete) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_q == OP_MODE) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          result          = cell_value[MID];
          load_out        = 1'b1;
          cell_ctrl.clear = 1'b1;
          state_next      = S_FILL;
        end
      end
      S_SCAN: begin
        cell_ctrl.shift = 1'b1;
        scan_ctrl.step  = 1'b1;
        scan_ctrl.first = (scan_idx == '0);
        if (scan_idx == FW'(WINDOW - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out        = 1'b1;
          cell_ctrl.clear = 1'b1;
          state_next      = S_FILL;
        end
      end
      default: state_next = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= complete ? '0 : fill_count + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      scan_idx <= scan_idx + FW'(1);
    end else begin
      scan_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= TDATA_W'(result);
    end
  end

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> ($countones(cell_valid) == int'(fill_count)))
    else $error("valid cells disagree with fill count");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (&ordered))
    else $error("window not sorted at evaluation");

  a_complete: assert property (@(posedge clk) disable iff (rst)
    (accept && complete) |=> (state == S_EVAL))
    else $error("completing word did not start evaluation");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_EVAL || $past(state) == S_EMIT))
    else $error("result appeared outside evaluation");

endmodule
